// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the percent decoder checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== src/pct_pkg.sv =====
// ----------------------------------------------------------------------------
// pct_pkg
// Shared types, constants and hex helpers for the URL percent decoder.
// ----------------------------------------------------------------------------
package pct_pkg;

    localparam logic [7:0] PCT_CHAR    = 8'h25;
    localparam int         MAX_RUN     = 3;
    localparam int         CNT_W       = 2;
    localparam int         QUEUE_DEPTH = 4;

    // One decoded run: up to three bytes for one input transaction.
    typedef struct packed {
        logic [MAX_RUN-1:0][7:0] bytes;
        logic [CNT_W-1:0]        cnt;
        logic                    last;
    } job_t;

    function automatic logic hex_valid(input logic [7:0] c);
        hex_valid = (c >= 8'h30 && c <= 8'h39) ||
                    (c >= 8'h41 && c <= 8'h46) ||
                    (c >= 8'h61 && c <= 8'h66);
    endfunction

    // Digits map straight from the low nibble; letters are offset by nine.
    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        hex_nibble = (c <= 8'h39) ? c[3:0] : (c[3:0] + 4'd9);
    endfunction

endpackage

// ===== src/pct_queue.sv =====
// ----------------------------------------------------------------------------
// pct_queue
// Small FIFO of decoded runs between the classifier and the output sequencer.
// ----------------------------------------------------------------------------
module pct_queue #(
    parameter int DEPTH = pct_pkg::QUEUE_DEPTH
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  pct_pkg::job_t push_job,
    input  logic          pop,
    output logic          full,
    output logic          not_empty,
    output pct_pkg::job_t head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    pct_pkg::job_t     mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;

    assign full      = (fill_reg == FILL_W'(DEPTH));
    assign not_empty = (fill_reg != '0);
    assign head_job  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== src/pct_front.sv =====
// ----------------------------------------------------------------------------
// pct_front
// Escape tracker: classifies each input byte and builds its output run.
// ----------------------------------------------------------------------------
module pct_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_fire,
    input  logic [7:0]    in_byte,
    input  logic          in_last,
    output logic          push,
    output pct_pkg::job_t push_job
);

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_PCT   = 3'b010,
        PH_DIGIT = 3'b100
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] held_reg, held_next;
    logic       is_hex;
    logic       opens_pct;

    assign is_hex    = pct_pkg::hex_valid(in_byte);
    assign opens_pct = (in_byte == pct_pkg::PCT_CHAR) && !in_last;

    always_comb begin
        phase_next = phase_reg;
        held_next  = held_reg;
        push_job   = '0;
        push_job.last = in_last;
        unique case (phase_reg)
            PH_PCT: begin
                priority if (is_hex && !in_last) begin
                    held_next  = in_byte;
                    phase_next = PH_DIGIT;
                end else if (is_hex || !opens_pct) begin
                    // broken or short escape: literal '%' then the byte
                    push_job.bytes[0] = pct_pkg::PCT_CHAR;
                    push_job.bytes[1] = in_byte;
                    push_job.cnt      = 2'd2;
                    phase_next        = PH_IDLE;
                end else begin
                    // '%' after '%': emit the first, hold the second
                    push_job.bytes[0] = pct_pkg::PCT_CHAR;
                    push_job.cnt      = 2'd1;
                    phase_next        = PH_PCT;
                end
            end
            PH_DIGIT: begin
                priority if (is_hex) begin
                    push_job.bytes[0] = {pct_pkg::hex_nibble(held_reg),
                                         pct_pkg::hex_nibble(in_byte)};
                    push_job.cnt      = 2'd1;
                    phase_next        = PH_IDLE;
                end else if (opens_pct) begin
                    push_job.bytes[0] = pct_pkg::PCT_CHAR;
                    push_job.bytes[1] = held_reg;
                    push_job.cnt      = 2'd2;
                    phase_next        = PH_PCT;
                end else begin
                    push_job.bytes[0] = pct_pkg::PCT_CHAR;
                    push_job.bytes[1] = held_reg;
                    push_job.bytes[2] = in_byte;
                    push_job.cnt      = 2'd3;
                    phase_next        = PH_IDLE;
                end
            end
            default: begin
                // idle, and any unused code
                if (opens_pct) begin
                    phase_next = PH_PCT;
                end else begin
                    push_job.bytes[0] = in_byte;
                    push_job.cnt      = 2'd1;
                    phase_next        = PH_IDLE;
                end
            end
        endcase
        if (in_last) begin
            phase_next = PH_IDLE;
        end
    end

    assign push = in_fire && (push_job.cnt != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
        end else if (in_fire) begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            held_reg <= held_next;
        end
    end

endmodule

// ===== src/pct_back.sv =====
// ----------------------------------------------------------------------------
// pct_back
// Output sequencer: walks each queued run one byte per transaction.
// ----------------------------------------------------------------------------
module pct_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          job_valid,
    input  pct_pkg::job_t head_job,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_byte,
    output logic          run_end,
    output logic          string_end
);

    logic [pct_pkg::CNT_W-1:0] idx_reg, idx_next;
    logic                      valid_reg;
    logic [7:0]                byte_reg;
    logic                      run_end_reg;
    logic                      string_end_reg;
    logic                      load;
    logic                      is_end;
    logic [7:0]                sel_byte;

    assign load   = job_valid && (!valid_reg || out_ready);
    assign is_end = ((idx_reg + 1'b1) == head_job.cnt);
    assign pop    = load && is_end;

    always_comb begin
        unique case (idx_reg)
            2'd0:    sel_byte = head_job.bytes[0];
            2'd1:    sel_byte = head_job.bytes[1];
            default: sel_byte = head_job.bytes[2];
        endcase
    end

    always_comb begin
        idx_next = idx_reg;
        if (load) begin
            idx_next = is_end ? '0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            idx_reg <= idx_next;
            if (load) begin
                valid_reg <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg       <= sel_byte;
            run_end_reg    <= is_end;
            string_end_reg <= is_end && head_job.last;
        end
    end

    assign out_valid  = valid_reg;
    assign out_byte   = byte_reg;
    assign run_end    = run_end_reg;
    assign string_end = string_end_reg;

endmodule

// ===== src/url_percent_decoder.sv =====
// ----------------------------------------------------------------------------
// url_percent_decoder
// Streaming URL percent-escape decoder: "%hh" becomes one byte, all else
// passes through, held bytes are flushed at the end of the string.
// ----------------------------------------------------------------------------
// m_tvalid rises after the queue write, then the output register load; the first
//   byte can be taken at the next edge.
// Throughput (m_tready high): one input per cycle while each input yields at most
//   one byte; the output register drains one byte per cycle, so a run of two or
//   three bytes (broken escape, flush at string end) goes out byte by byte. The
//   run queue absorbs short bursts of such runs before s_tready drops.
// Reset (aresetn low, synchronous): escape state idle, queue empty, m_tvalid low.
// ----------------------------------------------------------------------------
module url_percent_decoder #(
    parameter int QUEUE_DEPTH = pct_pkg::QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    // input stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // in_last: final byte of the string
    // decoded stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,   // run_end: last byte caused by one input
    output logic [0:0] m_tuser    // [0] string_end: final byte of the string
);

    logic          in_fire;
    logic          push;
    pct_pkg::job_t push_job;
    logic          pop;
    logic          q_full;
    logic          q_not_empty;
    pct_pkg::job_t head_job;
    logic          string_end;

    // Front side only needs room for one more run.
    assign s_tready = !q_full;
    assign in_fire  = s_tvalid && s_tready;

    // Escape tracking; steps that only extend an escape push nothing.
    pct_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .push     (push),
        .push_job (push_job)
    );

    // Decouples classification from byte-by-byte output.
    pct_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_job  (head_job)
    );

    // Output register; the next byte loads while the current one is taken.
    pct_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .job_valid  (q_not_empty),
        .head_job   (head_job),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_byte   (m_tdata),
        .run_end    (m_tlast),
        .string_end (string_end)
    );

    assign m_tuser = string_end;

endmodule

// ===== src/pct_checker.sv =====
// ----------------------------------------------------------------------------
// pct_checker
// Port-level checks for url_percent_decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pct_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic [0:0] m_tuser
);

    // A stalled result transaction holds its payload.
    `ASSERT_CLK(a_out_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser)), "m_* changed while stalled")

    // String end only closes a run.
    `ASSERT_CLK(a_end_in_run, (m_tvalid && m_tuser[0]) |-> m_tlast, "string end without run end")

    // Nothing is presented right after reset.
    `ASSERT_ALWAYS(a_reset_quiet, !aresetn |=> !m_tvalid, "m_tvalid high after reset")

    // No string-closing result shows up in the cycle after a reset cycle.
    `ASSERT_ALWAYS(a_no_accept_in_reset, !aresetn |=> !(m_tvalid && m_tlast && m_tuser[0] && $past(!aresetn)), "result during reset")

endmodule

bind url_percent_decoder pct_checker u_pct_checker (.*);

// ===== tb/sv/url_percent_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// url_percent_decoder_tb
// Self-checking bench for the streaming URL percent-escape decoder. A short
// directed table covers escapes, broken escapes, short tails and both byte
// extremes. Random strings follow: mostly well-formed escapes mixed with
// broken ones and raw bytes. Every decoded transaction is compared with the
// table or the bench-side decoder model. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module url_percent_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] PCT_CHAR = pct_pkg::PCT_CHAR;

    localparam int RANDOM_ITEMS = 400;
    localparam int CYCLE_LIMIT  = 200000;  // far above the slowest legal run
    localparam int DRAIN_CYCLES = 20;      // idle wait after the expected queue empties

    // Escape tracking inside the bench decoder
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,   // nothing pending
        PH_PCT   = 2'd1,   // '%' held
        PH_DIGIT = 2'd2    // '%' and one hex digit held
    } esc_phase_t;

    // One decoded byte as it should appear on m_*
    typedef struct {
        logic [7:0] data;
        logic       run_end;
        logic       str_end;
    } dec_byte_t;

    // Directed table row; typed rows carry their decoded bytes inline
    typedef struct {
        logic [7:0] b;
        logic       last;
        bit         typed;
        int         n;
        logic [7:0] d0, d1, d2;
    } stim_row_t;

    // DUT interface
    logic       aclk;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] in_byte
    logic       s_tlast  = 1'b0;    // in_last
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [7:0] out_byte
    logic       m_tlast;            // run_end
    logic [0:0] m_tuser;            // [0] string_end

    // Bench decoder state
    esc_phase_t esc_phase = PH_IDLE;
    logic [7:0] held_byte = 8'h00;

    dec_byte_t  decoded_q[$];       // expected output transactions, oldest first
    stim_row_t  directed_q[$];
    int         err_cnt    = 0;
    int         cycles     = 0;
    bit         send_quiet = 1'b0;  // sender: no gaps while set
    bit         recv_quiet = 1'b0;  // receiver: no stalls while set

    url_percent_decoder uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hex digit value, -1 for anything else
    function automatic int hex_val(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        return -1;
    endfunction

    // Decode one input byte: update the escape state, return the bytes it releases
    function automatic void decode_byte(input logic [7:0] b, input logic last,
                                        ref dec_byte_t run[$]);
        int hv;
        bit as_plain;
        logic [7:0] val;
        hv       = hex_val(b);
        as_plain = 1'b0;
        run.delete();
        case (esc_phase)
            PH_PCT: begin
                if (hv >= 0 && !last) begin
                    held_byte = b;
                    esc_phase = PH_DIGIT;
                end else if (hv >= 0) begin
                    // string ends after '%h': both flushed literally
                    run.push_back('{PCT_CHAR, 1'b0, 1'b0});
                    run.push_back('{b, 1'b0, 1'b0});
                    esc_phase = PH_IDLE;
                end else begin
                    run.push_back('{PCT_CHAR, 1'b0, 1'b0});
                    as_plain = 1'b1;
                end
            end
            PH_DIGIT: begin
                if (hv >= 0) begin
                    val = 8'((hex_val(held_byte) << 4) + hv);
                    run.push_back('{val, 1'b0, 1'b0});
                    esc_phase = PH_IDLE;
                end else begin
                    run.push_back('{PCT_CHAR, 1'b0, 1'b0});
                    run.push_back('{held_byte, 1'b0, 1'b0});
                    as_plain = 1'b1;
                end
            end
            default: as_plain = 1'b1;
        endcase
        // broken escape falls back here; the byte may open a new escape
        if (as_plain) begin
            if (b == PCT_CHAR && !last) begin
                esc_phase = PH_PCT;
            end else begin
                run.push_back('{b, 1'b0, 1'b0});
                esc_phase = PH_IDLE;
            end
        end
        if (run.size() > 0) begin
            run[run.size()-1].run_end = 1'b1;
            run[run.size()-1].str_end = last;
        end
        if (last) esc_phase = PH_IDLE;
    endfunction

    function automatic void add_row(input logic [7:0] b, input logic last,
                                    input bit typed = 1'b0, input int n = 0,
                                    input logic [7:0] d0 = 8'h00,
                                    input logic [7:0] d1 = 8'h00,
                                    input logic [7:0] d2 = 8'h00);
        directed_q.push_back('{b, last, typed, n, d0, d1, d2});
    endfunction

    function automatic logic [7:0] pick_hex();
        int v;
        v = $urandom_range(0, 21);
        if (v < 10) return 8'("0" + v);
        if (v < 16) return 8'("A" + v - 10);
        return 8'("a" + v - 16);
    endfunction

    function automatic logic [7:0] pick_nonhex();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (hex_val(c) >= 0);
        return c;
    endfunction

    // Drive one input transaction, then queue what it should decode to.
    // Typed rows replace the model's bytes with the ones from the table.
    task automatic send_byte(input logic [7:0] b, input logic last,
                             input bit typed = 1'b0, input int n = 0,
                             input logic [7:0] d0 = 8'h00,
                             input logic [7:0] d1 = 8'h00,
                             input logic [7:0] d2 = 8'h00);
        dec_byte_t  run[$];
        logic [7:0] tb_bytes[3];
        int         gap;
        gap = send_quiet ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        decode_byte(b, last, run);
        if (typed) begin
            tb_bytes = '{d0, d1, d2};
            run.delete();
            for (int i = 0; i < n; i++)
                run.push_back('{tb_bytes[i], i == n - 1, last && (i == n - 1)});
        end
        foreach (run[i]) decoded_q.push_back(run[i]);
    endtask

    // One random string, last byte flagged. Mostly good escapes, some broken.
    task automatic send_string(ref int sent);
        logic [7:0] str[$];
        int tokens;
        int r;
        tokens = $urandom_range(1, 10);
        repeat (tokens) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                str.push_back(PCT_CHAR); str.push_back(pick_hex()); str.push_back(pick_hex());
            end else if (r < 70) begin
                str.push_back(8'($urandom_range(0, 255)));
            end else if (r < 80) begin
                str.push_back(PCT_CHAR); str.push_back(pick_nonhex());
            end else if (r < 88) begin
                str.push_back(PCT_CHAR); str.push_back(pick_hex()); str.push_back(pick_nonhex());
            end else if (r < 94) begin
                str.push_back(PCT_CHAR); str.push_back(PCT_CHAR);
            end else begin
                str.push_back(PCT_CHAR);
            end
        end
        // short tail: string stops in the middle of an escape
        r = $urandom_range(0, 9);
        if (r < 2) begin
            str.push_back(PCT_CHAR);
            if (r == 1) str.push_back(pick_hex());
        end
        send_quiet = ($urandom_range(0, 3) == 0);
        foreach (str[i]) send_byte(str[i], i == str.size() - 1);
        sent += str.size();
    endtask

    // ------------------------------------------------------------------------
    // Stimulus: reset, directed table, random strings, drain, verdict
    // ------------------------------------------------------------------------
    initial begin
        int sent;
        sent = 0;
        // reset and extremes
        add_row(8'h00, 1'b0, 1'b1, 1, 8'h00);
        add_row(8'hFF, 1'b0, 1'b1, 1, 8'hFF);
        // upper-case escape; the two pending steps release nothing
        add_row(PCT_CHAR, 1'b0);
        add_row("4", 1'b0);
        add_row("1", 1'b0, 1'b1, 1, 8'h41);
        // mixed-case escape
        add_row(PCT_CHAR, 1'b0);
        add_row("a", 1'b0);
        add_row("F", 1'b0);
        // broken escape right after '%'
        add_row(PCT_CHAR, 1'b0);
        add_row("G", 1'b0, 1'b1, 2, PCT_CHAR, "G");
        // broken escape after one digit
        add_row(PCT_CHAR, 1'b0);
        add_row("9", 1'b0);
        add_row("z", 1'b0);
        // '%' breaks an escape and opens a new one
        add_row(PCT_CHAR, 1'b0);
        add_row(PCT_CHAR, 1'b0);
        add_row("3", 1'b0);
        add_row("0", 1'b0);
        // short tail: '%', digit, then a non-hex final byte
        add_row(PCT_CHAR, 1'b0);
        add_row("7", 1'b0);
        add_row("x", 1'b1, 1'b1, 3, PCT_CHAR, "7", "x");
        // lone '%' as the whole string
        add_row(PCT_CHAR, 1'b1, 1'b1, 1, PCT_CHAR);
        // string ends after '%' and one hex digit
        add_row(PCT_CHAR, 1'b0);
        add_row("4", 1'b1, 1'b1, 2, PCT_CHAR, "4");
        // complete escape on the final byte
        add_row(PCT_CHAR, 1'b0);
        add_row("4", 1'b0);
        add_row("1", 1'b1, 1'b1, 1, 8'h41);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_q[i])
            send_byte(directed_q[i].b, directed_q[i].last, directed_q[i].typed,
                      directed_q[i].n, directed_q[i].d0, directed_q[i].d1,
                      directed_q[i].d2);

        while (sent < RANDOM_ITEMS) send_string(sent);
        s_tvalid <= 1'b0;

        while (decoded_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (err_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: random stall before each output transaction, quiet stretches
    // ------------------------------------------------------------------------
    initial begin
        int stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if ($urandom_range(0, 31) == 0) recv_quiet = !recv_quiet;
            stall = recv_quiet ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // ------------------------------------------------------------------------
    // Checker: each accepted output transaction against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        dec_byte_t exp_b;
        if (aresetn && m_tvalid && m_tready) begin
            if (decoded_q.size() == 0) begin
                $error("unexpected output transaction: out_byte %02h", m_tdata);
                err_cnt++;
            end else begin
                exp_b = decoded_q.pop_front();
                if (m_tdata !== exp_b.data) begin
                    $error("out_byte: expected %02h, got %02h", exp_b.data, m_tdata);
                    err_cnt++;
                end
                if (m_tlast !== exp_b.run_end) begin
                    $error("run_end: expected %0b, got %0b", exp_b.run_end, m_tlast);
                    err_cnt++;
                end
                if (m_tuser[0] !== exp_b.str_end) begin
                    $error("string_end: expected %0b, got %0b", exp_b.str_end, m_tuser[0]);
                    err_cnt++;
                end
            end
        end
    end

    // Hang guard
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

endmodule

// ===== sim.f =====
+incdir+src
src/pct_pkg.sv
src/pct_queue.sv
src/pct_front.sv
src/pct_back.sv
src/url_percent_decoder.sv
src/pct_checker.sv
tb/sv/url_percent_decoder_tb.sv
